### rtl/dlstq_pkg.sv
// Package for the delta-list sleep timer queue.
// Holds sizes, operation and result codes, and beat payload structs; no dependencies.
package dlstq_pkg;

  localparam int MaxSleepers = 16;
  localparam int DelayWidth = 16;
  localparam int IdxW = $clog2(MaxSleepers);
  localparam int CntW = $clog2(MaxSleepers + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_TICK   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_INSERTED = 3'd0,
    K_FULL     = 3'd1,
    K_REMOVED  = 3'd2,
    K_NOTFOUND = 3'd3,
    K_WOKEN    = 3'd4,
    K_NONE     = 3'd5
  } kind_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  thread_id;
    logic [15:0] delay;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] woken_id;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    op_t                   op;
    logic [7:0]            tid;
    logic [DelayWidth-1:0] delay;
  } cmd_t;

endpackage

### rtl/dlstq_front.sv
// Front end of the sleep timer queue: accepts input beats, drops unused codes,
// and holds classified commands in a two-entry queue. Depends on dlstq_pkg.
module dlstq_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dlstq_pkg::in_beat_t in_data,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output dlstq_pkg::cmd_t    cmd
);

  dlstq_pkg::cmd_t q_r [2];
  dlstq_pkg::cmd_t q_nxt0, q_nxt1;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  dlstq_pkg::cmd_t c_in;

  always_comb begin
    c_in.op = dlstq_pkg::op_t'(in_data.op);
    c_in.tid = in_data.thread_id;
    c_in.delay = (in_data.delay == '0) ? 16'd1 : in_data.delay;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready && (in_data.op != dlstq_pkg::OP_UNUSED);
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q_r[0];

  always_comb begin
    q_nxt0 = q_r[0];
    q_nxt1 = q_r[1];
    cnt_nxt = cnt_r;
    if (pop) begin
      q_nxt0 = q_r[1];
    end
    if (push) begin
      if ((cnt_r == 2'd0) || (cnt_r == 2'd1 && pop)) begin
        q_nxt0 = c_in;
      end else begin
        q_nxt1 = c_in;
      end
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt0;
    q_r[1] <= q_nxt1;
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/dlstq_back.sv
// Back end of the sleep timer queue: walks the delta list one slot per cycle
// and emits result beats through an output register. Depends on dlstq_pkg.
module dlstq_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  dlstq_pkg::cmd_t       cmd,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dlstq_pkg::out_beat_t  out_data
);

  localparam int DW = dlstq_pkg::DelayWidth;
  localparam int IW = dlstq_pkg::IdxW;
  localparam int CW = dlstq_pkg::CntW;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_INSSCN = 6'b000010,
    S_SHIFT  = 6'b000100,
    S_REMSCN = 6'b001000,
    S_PULL   = 6'b010000,
    S_TICK   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [7:0]    id_r [dlstq_pkg::MaxSleepers];
  logic [DW-1:0] dl_r [dlstq_pkg::MaxSleepers];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [DW-1:0] dly_r, dly_nxt;
  logic [7:0]    tid_r, tid_nxt;
  logic          ov_r, ov_nxt;
  dlstq_pkg::out_beat_t od_r, od_nxt;
  logic          out_free;
  logic          wr_en, wr2_en;
  logic [IW-1:0] wr_a, wr2_a;
  logic [7:0]    wr_id;
  logic [DW-1:0] wr_dl, wr2_dl;
  logic [IW-1:0] pi, ii, ii1;

  assign out_valid = ov_r;
  assign out_data = od_r;
  assign out_free = !ov_r || out_ready;
  assign cmd_ready = (state_r == S_IDLE) && out_free;
  assign pi = pos_r[IW-1:0];
  assign ii = i_r[IW-1:0];
  assign ii1 = IW'(i_r - CW'(1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    i_nxt = i_r;
    dly_nxt = dly_r;
    tid_nxt = tid_r;
    ov_nxt = ov_r && !out_ready;
    od_nxt = od_r;
    wr_en = 1'b0;
    wr_a = '0;
    wr_id = '0;
    wr_dl = '0;
    wr2_en = 1'b0;
    wr2_a = '0;
    wr2_dl = '0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          tid_nxt = cmd.tid;
          dly_nxt = cmd.delay;
          pos_nxt = '0;
          case (cmd.op)
            dlstq_pkg::OP_INSERT: begin
              if (cnt_r == CW'(dlstq_pkg::MaxSleepers)) begin
                ov_nxt = 1'b1;
                od_nxt = '{dlstq_pkg::K_FULL, 8'd0, 1'b1};
              end else begin
                state_nxt = S_INSSCN;
              end
            end
            dlstq_pkg::OP_REMOVE: state_nxt = S_REMSCN;
            dlstq_pkg::OP_TICK: begin
              if (cnt_r == '0) begin
                ov_nxt = 1'b1;
                od_nxt = '{dlstq_pkg::K_NONE, 8'd0, 1'b1};
              end else begin
                state_nxt = S_TICK;
                if (dl_r[0] != '0) begin
                  wr2_en = 1'b1;
                  wr2_a = '0;
                  wr2_dl = dl_r[0] - DW'(1);
                  if (dl_r[0] != DW'(1)) begin
                    state_nxt = S_IDLE;
                    ov_nxt = 1'b1;
                    od_nxt = '{dlstq_pkg::K_NONE, 8'd0, 1'b1};
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_INSSCN: begin
        if (pos_r < cnt_r && dl_r[pi] <= dly_r) begin
          dly_nxt = dly_r - dl_r[pi];
          pos_nxt = pos_r + CW'(1);
        end else begin
          if (pos_r < cnt_r) begin
            wr2_en = 1'b1;
            wr2_a = pi;
            wr2_dl = dl_r[pi] - dly_r;
          end
          i_nxt = cnt_r;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (i_r > pos_r) begin
          wr_en = 1'b1;
          wr_a = ii;
          wr_id = id_r[ii1];
          wr_dl = dl_r[ii1];
          i_nxt = i_r - CW'(1);
        end else if (out_free) begin
          wr_en = 1'b1;
          wr_a = pi;
          wr_id = tid_r;
          wr_dl = dly_r;
          cnt_nxt = cnt_r + CW'(1);
          ov_nxt = 1'b1;
          od_nxt = '{dlstq_pkg::K_INSERTED, tid_r, 1'b1};
          state_nxt = S_IDLE;
        end
      end
      S_REMSCN: begin
        if (pos_r >= cnt_r) begin
          if (out_free) begin
            ov_nxt = 1'b1;
            od_nxt = '{dlstq_pkg::K_NOTFOUND, 8'd0, 1'b1};
            state_nxt = S_IDLE;
          end
        end else if (id_r[pi] == tid_r) begin
          if (pos_r + CW'(1) < cnt_r) begin
            wr2_en = 1'b1;
            wr2_a = IW'(pos_r + CW'(1));
            wr2_dl = dl_r[IW'(pos_r + CW'(1))] + dl_r[pi];
          end
          i_nxt = pos_r;
          state_nxt = S_PULL;
        end else begin
          pos_nxt = pos_r + CW'(1);
        end
      end
      S_PULL: begin
        if (i_r + CW'(1) < cnt_r) begin
          wr_en = 1'b1;
          wr_a = ii;
          wr_id = id_r[IW'(i_r + CW'(1))];
          wr_dl = dl_r[IW'(i_r + CW'(1))];
          i_nxt = i_r + CW'(1);
        end else if (out_free) begin
          cnt_nxt = cnt_r - CW'(1);
          ov_nxt = 1'b1;
          od_nxt = '{dlstq_pkg::K_REMOVED, tid_r, 1'b1};
          state_nxt = S_IDLE;
        end
      end
      S_TICK: begin
        // Head delta is zero here: emit it, then shift the list down one slot.
        if (pos_r == '0) begin
          if (out_free) begin
            ov_nxt = 1'b1;
            od_nxt.kind = dlstq_pkg::K_WOKEN;
            od_nxt.woken_id = id_r[0];
            od_nxt.last = !(cnt_r > CW'(1) && dl_r[1] == '0);
            i_nxt = '0;
            pos_nxt = CW'(1);
          end
        end else if (i_r + CW'(1) < cnt_r) begin
          wr_en = 1'b1;
          wr_a = ii;
          wr_id = id_r[IW'(i_r + CW'(1))];
          wr_dl = dl_r[IW'(i_r + CW'(1))];
          i_nxt = i_r + CW'(1);
        end else begin
          cnt_nxt = cnt_r - CW'(1);
          pos_nxt = '0;
          state_nxt = od_r.last ? S_IDLE : S_TICK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_r[wr_a] <= wr_id;
      dl_r[wr_a] <= wr_dl;
    end
    if (wr2_en) begin
      dl_r[wr2_a] <= wr2_dl;
    end
    pos_r <= pos_nxt;
    i_r <= i_nxt;
    dly_r <= dly_nxt;
    tid_r <= tid_nxt;
    od_r <= od_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
    end
  end

endmodule

### rtl/delta_list_sleep_timer_queue.sv
// Top level of the delta-list sleep timer queue: front queue and list engine.
// Insert and remove walk one slot a cycle.
// A tick emits one beat per woken thread.
// The front queue holds two commands. Synchronous active-low reset empties the list.
// Depends on dlstq_pkg, dlstq_front and dlstq_back.
module delta_list_sleep_timer_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dlstq_pkg::in_beat_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dlstq_pkg::out_beat_t  out_data
);

  logic            cmd_valid, cmd_ready;
  dlstq_pkg::cmd_t cmd;

  dlstq_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  dlstq_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd(cmd), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

### rtl/dlstq_checker.sv
// Port-level checker for the delta-list sleep timer queue, bound to the top level.
// Depends on dlstq_pkg.
module dlstq_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input dlstq_pkg::out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.kind <= dlstq_pkg::K_NONE)
    else $error("bad result kind");

  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == dlstq_pkg::K_FULL ||
      out_data.kind == dlstq_pkg::K_NOTFOUND || out_data.kind == dlstq_pkg::K_NONE)
      |-> out_data.woken_id == 8'd0 && out_data.last)
    else $error("status beat carries an id or is not last");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != dlstq_pkg::K_WOKEN |-> out_data.last)
    else $error("non-wake beat not last");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind delta_list_sleep_timer_queue dlstq_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
